[design/u16550_pkg.sv]
// Shared types and constants for the 16550-style UART register model.
// Holds item mode codes, register offsets, status bit values and the
// per-item result record passed from the register file to the top level.
package u16550_pkg;

	typedef enum logic [1:0] {
		MODE_BUS_READ  = 2'd0,
		MODE_BUS_WRITE = 2'd1,
		MODE_RX_PUSH   = 2'd2,
		MODE_TX_POP    = 2'd3
	} mode_t;

	// Register offsets, 16550 layout
	localparam logic [2:0] OFF_DATA = 3'd0;  // RBR / THR / DLL
	localparam logic [2:0] OFF_IER  = 3'd1;  // IER / DLM
	localparam logic [2:0] OFF_IIR  = 3'd2;  // IIR / FCR
	localparam logic [2:0] OFF_LCR  = 3'd3;
	localparam logic [2:0] OFF_MCR  = 3'd4;
	localparam logic [2:0] OFF_LSR  = 3'd5;
	localparam logic [2:0] OFF_MSR  = 3'd6;
	localparam logic [2:0] OFF_SCR  = 3'd7;

	localparam int LCR_DLAB_BIT     = 7;
	localparam int IER_RX_DATA_BIT  = 0;
	localparam int IER_TX_EMPTY_BIT = 1;

	localparam logic [7:0] IIR_NO_INT     = 8'h01;
	localparam logic [7:0] IIR_TX_EMPTY   = 8'h02;
	localparam logic [7:0] IIR_RX_DATA    = 8'h04;
	localparam logic [7:0] LSR_DATA_READY = 8'h01;
	localparam logic [7:0] LSR_TX_IDLE    = 8'h60;
	localparam logic [7:0] MSR_FIXED      = 8'hB0;
	localparam logic [7:0] DLL_RESET      = 8'h01;

	localparam int IN_BITS  = 24;
	localparam int OUT_BITS = 120;

	// Result of one item, ready except for ring read data
	typedef struct packed {
		logic [7:0]  rdata;      // register read value (not RBR data)
		logic        rx_sel;     // read_data comes from receive ring
		logic        tx_sel;     // tx_byte comes from transmit ring
		logic        done;
		logic        irq_level;
		logic        irq_edge;
		logic [31:0] dropped;
		logic [31:0] written;
		logic [31:0] events;
	} result_t;

	// Ring status seen by the register file
	typedef struct packed {
		logic empty;
		logic full;
		logic one_left;          // a pop would leave the ring empty
	} ring_stat_t;

endpackage

[design/u16550_ring.sv]
// Byte ring with one unused slot: memory, read and write pointers.
// Read data is registered and holds until the next pop.
// Depends on u16550_pkg for the status record.
module u16550_ring import u16550_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] push_data,
	input  logic       pop,
	output ring_stat_t stat,
	output logic [7:0] pop_data
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_nxt;
	logic [AW-1:0] wr_nxt;
	logic [7:0]    pop_data_q;

	// Wrap pointers at the ring depth
	assign rd_nxt = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign wr_nxt = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;

	assign stat.empty    = (rd_ptr_q == wr_ptr_q);
	assign stat.full     = (wr_nxt == rd_ptr_q);
	assign stat.one_left = (rd_nxt == wr_ptr_q);
	assign pop_data      = pop_data_q;

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_nxt;
			if (pop)
				rd_ptr_q <= rd_nxt;
		end
	end

	// Write entry, register read data on pop
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
		if (pop)
			pop_data_q <= mem[rd_ptr_q];
	end

endmodule

[design/u16550_regs.sv]
// Register file, interrupt logic and event counters of the UART model.
// Decides ring pushes and pops for each accepted item; uses u16550_pkg.
module u16550_regs import u16550_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  mode_t      mode,
	input  logic [2:0] offset,
	input  logic [7:0] write_data,
	input  ring_stat_t tx_stat,
	input  ring_stat_t rx_stat,
	output logic       tx_push,
	output logic       tx_pop,
	output logic       rx_push,
	output logic       rx_pop,
	output result_t    res
);

	logic [7:0]  ier_q, lcr_q, mcr_q, scr_q, dll_q, dlm_q;
	logic        thre_q;
	logic [31:0] dropped_q, written_q, events_q;

	logic [7:0]  ier_d;
	logic        thre_d;
	logic [7:0]  rd_val;
	logic        dlab;
	logic        irq_before, irq_after, rx_wait_after, edge_hit;
	logic        reg_wr;
	logic        thr_wr;
	logic        drop;

	assign dlab   = lcr_q[LCR_DLAB_BIT];
	assign reg_wr = (mode == MODE_BUS_WRITE);
	assign thr_wr = reg_wr && (offset == OFF_DATA) && !dlab;

	// Ring requests
	assign tx_push = take && thr_wr && !tx_stat.full;
	assign drop    = thr_wr && tx_stat.full;
	assign tx_pop  = take && (mode == MODE_TX_POP) && !tx_stat.empty;
	assign rx_push = take && (mode == MODE_RX_PUSH) && !rx_stat.full;
	assign rx_pop  = take && (mode == MODE_BUS_READ) && (offset == OFF_DATA) && !dlab
		&& !rx_stat.empty;

	// Next IER and THRE latch, read value
	always_comb begin
		ier_d  = ier_q;
		thre_d = thre_q;
		rd_val = '0;
		case (mode)
			MODE_BUS_READ: begin
				case (offset)
					OFF_DATA: rd_val = dlab ? dll_q : 8'h00;
					OFF_IER:  rd_val = dlab ? dlm_q : ier_q;
					OFF_IIR: begin
						if (ier_q[IER_RX_DATA_BIT] && !rx_stat.empty) begin
							rd_val = IIR_RX_DATA;
						end else if (ier_q[IER_TX_EMPTY_BIT] && thre_q) begin
							rd_val = IIR_TX_EMPTY;
							thre_d = 1'b0;
						end else begin
							rd_val = IIR_NO_INT;
						end
					end
					OFF_LCR: rd_val = lcr_q;
					OFF_MCR: rd_val = mcr_q;
					OFF_LSR: rd_val = (tx_stat.full ? 8'h00 : LSR_TX_IDLE)
						| (rx_stat.empty ? 8'h00 : LSR_DATA_READY);
					OFF_MSR: rd_val = MSR_FIXED;
					default: rd_val = scr_q;
				endcase
			end
			MODE_BUS_WRITE: begin
				if (thr_wr)
					thre_d = !tx_stat.full;
				else if (offset == OFF_IER && !dlab) begin
					ier_d = write_data;
					if (write_data[IER_TX_EMPTY_BIT] && !ier_q[IER_TX_EMPTY_BIT])
						thre_d = 1'b1;
				end
			end
			MODE_TX_POP: begin
				if (!tx_stat.empty && tx_stat.full)
					thre_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Interrupt condition before and after the item
	always_comb begin
		if (rx_push)
			rx_wait_after = 1'b1;
		else if (rx_pop)
			rx_wait_after = !rx_stat.one_left;
		else
			rx_wait_after = !rx_stat.empty;
		irq_before = (ier_q[IER_RX_DATA_BIT] && !rx_stat.empty)
			|| (ier_q[IER_TX_EMPTY_BIT] && thre_q);
		irq_after  = (ier_d[IER_RX_DATA_BIT] && rx_wait_after)
			|| (ier_d[IER_TX_EMPTY_BIT] && thre_d);
		edge_hit   = (mode != MODE_BUS_READ) && !irq_before && irq_after;
	end

	assign res.rdata     = rd_val;
	assign res.rx_sel    = rx_pop;
	assign res.tx_sel    = tx_pop;
	assign res.done      = rx_push || tx_pop;
	assign res.irq_level = irq_after;
	assign res.irq_edge  = edge_hit;
	assign res.dropped   = dropped_q + 32'(drop);
	assign res.written   = written_q + 32'(tx_push);
	assign res.events    = events_q + 32'(edge_hit);

	// Commit state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q     <= '0;
			lcr_q     <= '0;
			mcr_q     <= '0;
			scr_q     <= '0;
			dll_q     <= DLL_RESET;
			dlm_q     <= '0;
			thre_q    <= 1'b0;
			dropped_q <= '0;
			written_q <= '0;
			events_q  <= '0;
		end else if (take) begin
			ier_q     <= ier_d;
			thre_q    <= thre_d;
			dropped_q <= res.dropped;
			written_q <= res.written;
			events_q  <= res.events;
			// FCR writes have no visible effect; LSR and MSR ignore writes
			if (reg_wr) begin
				case (offset)
					OFF_DATA: if (dlab) dll_q <= write_data;
					OFF_IER:  if (dlab) dlm_q <= write_data;
					OFF_LCR:  lcr_q <= write_data;
					OFF_MCR:  mcr_q <= write_data;
					OFF_SCR:  scr_q <= write_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[design/uart_16550_register_model_core.sv]
// Top level of the 16550-style UART register model: stream ports,
// one result stage and an output register. Uses u16550_pkg,
// u16550_regs and two u16550_ring instances.
//
// Usage: each input beat on s_* is one item (bus read, bus write, host
// receive enqueue or host transmit dequeue); each item yields exactly one
// result beat on m_*, in order.
// Order: the result stage loads with the input beat, and the output
// register loads from the result stage once it is free; m_tvalid
// comes from the output register.
// Throughput: one item per cycle while the output moves; register, pointer
// and counter updates complete in the accept cycle, and ring bytes come
// from each ring's single registered read port.
// Stall: with m_tready low the output register holds its beat and one more
// item is still taken into the result stage; s_tready then drops until the
// output moves.
// Reset: arst_n clears all registers, pointers, counters and both stages;
// DLL resets to 1. Ring contents are not cleared and need not be.
module uart_16550_register_model_core import u16550_pkg::*; #(
	parameter int TX_DEPTH = 256,
	parameter int RX_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// mode[1:0], offset[4:2], write_data[12:5], rx_byte[20:13], zero pad
	input  logic [IN_BITS-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// read_data[7:0], done_res[8], tx_byte[16:9], irq_level[17],
	// irq_edge[18], tx_dropped_count[50:19], tx_written_count[82:51],
	// irq_event_count[114:83], zero pad
	output logic [OUT_BITS-1:0] m_tdata
);

	logic          take;
	logic          adv_s1;
	logic          valid_s1;
	result_t       res;
	result_t       res_s1;
	logic          valid_q;
	logic [OUT_BITS-1:0] data_q;
	logic          tx_push, tx_pop, rx_push, rx_pop;
	ring_stat_t    tx_stat, rx_stat;
	logic [7:0]    tx_data, rx_data;
	logic [7:0]    read_byte, tx_byte;

	// Handshake: result stage moves when output register is free
	assign adv_s1   = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign take     = s_tvalid && s_tready;

	u16550_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.mode       (mode_t'(s_tdata[1:0])),
		.offset     (s_tdata[4:2]),
		.write_data (s_tdata[12:5]),
		.tx_stat    (tx_stat),
		.rx_stat    (rx_stat),
		.tx_push    (tx_push),
		.tx_pop     (tx_pop),
		.rx_push    (rx_push),
		.rx_pop     (rx_pop),
		.res        (res)
	);

	u16550_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tx_push),
		.push_data (s_tdata[12:5]),
		.pop       (tx_pop),
		.stat      (tx_stat),
		.pop_data  (tx_data)
	);

	u16550_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rx_push),
		.push_data (s_tdata[20:13]),
		.pop       (rx_pop),
		.stat      (rx_stat),
		.pop_data  (rx_data)
	);

	// Merge ring bytes into the result
	assign read_byte = res_s1.rx_sel ? rx_data : res_s1.rdata;
	assign tx_byte   = res_s1.tx_sel ? tx_data : 8'h00;

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

	// Hold payloads until their stage advances
	always_ff @(posedge clk) begin
		if (take)
			res_s1 <= res;
		if (adv_s1)
			data_q <= {5'd0, res_s1.events, res_s1.written, res_s1.dropped,
				res_s1.irq_edge, res_s1.irq_level, tx_byte, res_s1.done, read_byte};
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

[tb/uart_reply_checker.sv]
// Reply checker for the UART register model: mirrors the register file and both rings,
// predicts one reply per accepted request beat and compares replies in order.
// Depends on u16550_pkg for mode codes, register offsets and status values.
module uart_reply_checker import u16550_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// mode[1:0], offset[4:2], write_data[12:5], rx_byte[20:13], zero pad
	input  logic [IN_BITS-1:0]  s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// read_data[7:0], done_res[8], tx_byte[16:9], irq_level[17], irq_edge[18],
	// tx_dropped_count[50:19], tx_written_count[82:51], irq_event_count[114:83]
	input  logic [OUT_BITS-1:0] m_tdata,
	output int                  errors,
	output int                  pending
);

	localparam int TX_SLOTS = 256;
	localparam int RX_SLOTS = 64;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        done;
		logic [7:0]  tx_byte;
		logic        irq_level;
		logic        irq_edge;
		logic [31:0] dropped;
		logic [31:0] written;
		logic [31:0] events;
	} uart_reply_t;

	// Mirror of the register file and rings; pointers wrap at the ring size
	logic [7:0]  ier, lcr, mcr, scr, dll, dlm;
	logic        thre;
	logic [7:0]  tx_ring [TX_SLOTS];
	logic [7:0]  rx_ring [RX_SLOTS];
	logic [7:0]  tx_rd, tx_wr;
	logic [5:0]  rx_rd, rx_wr;
	logic [31:0] drop_cnt, sent_cnt, irq_cnt;

	uart_reply_t replies_due [$];
	uart_reply_t want, got;

	function automatic logic rx_has_data();
		return rx_rd != rx_wr;
	endfunction

	function automatic logic tx_is_full();
		return 8'(tx_wr + 1'b1) == tx_rd;
	endfunction

	function automatic logic irq_up();
		return (ier[IER_RX_DATA_BIT] && rx_has_data()) || (ier[IER_TX_EMPTY_BIT] && thre);
	endfunction

	// Apply one request to the mirror and return the reply it causes
	function automatic uart_reply_t reply_for(input mode_t op, input logic [2:0] off,
			input logic [7:0] wdata, input logic [7:0] rbyte);
		uart_reply_t r;
		logic        was_up, dlab, rise, full_before;
		r = '0;
		was_up = irq_up();
		dlab = lcr[LCR_DLAB_BIT];
		rise = 1'b0;
		case (op)
		MODE_BUS_READ: begin
			case (off)
			OFF_DATA: begin
				if (dlab) begin
					r.read_data = dll;
				end else if (rx_has_data()) begin
					r.read_data = rx_ring[rx_rd];
					rx_rd = rx_rd + 1'b1;
				end
			end
			OFF_IER: r.read_data = dlab ? dlm : ier;
			OFF_IIR: begin
				// receive data outranks the THRE latch; reporting THRE clears it
				if (ier[IER_RX_DATA_BIT] && rx_has_data()) begin
					r.read_data = IIR_RX_DATA;
				end else if (ier[IER_TX_EMPTY_BIT] && thre) begin
					thre = 1'b0;
					r.read_data = IIR_TX_EMPTY;
				end else begin
					r.read_data = IIR_NO_INT;
				end
			end
			OFF_LCR: r.read_data = lcr;
			OFF_MCR: r.read_data = mcr;
			OFF_LSR: r.read_data = (tx_is_full() ? 8'h00 : LSR_TX_IDLE) |
					(rx_has_data() ? LSR_DATA_READY : 8'h00);
			OFF_MSR: r.read_data = MSR_FIXED;
			default: r.read_data = scr;
			endcase
		end
		MODE_BUS_WRITE: begin
			case (off)
			OFF_DATA: begin
				if (dlab) begin
					dll = wdata;
				end else if (!tx_is_full()) begin
					tx_ring[tx_wr] = wdata;
					tx_wr = tx_wr + 1'b1;
					sent_cnt++;
					thre = 1'b1;
				end else begin
					// full ring: drop the byte
					drop_cnt++;
					thre = 1'b0;
				end
			end
			OFF_IER: begin
				if (dlab) begin
					dlm = wdata;
				end else begin
					if (wdata[IER_TX_EMPTY_BIT] && !ier[IER_TX_EMPTY_BIT])
						thre = 1'b1;
					ier = wdata;
				end
			end
			OFF_LCR: lcr = wdata;
			OFF_MCR: mcr = wdata;
			OFF_SCR: scr = wdata;
			// FCR has no visible effect; LSR and MSR ignore writes
			default: ;
			endcase
			rise = !was_up && irq_up();
		end
		MODE_RX_PUSH: begin
			if (6'(rx_wr + 1'b1) != rx_rd) begin
				rx_ring[rx_wr] = rbyte;
				rx_wr = rx_wr + 1'b1;
				r.done = 1'b1;
				rise = !was_up && irq_up();
			end
		end
		default: begin
			if (tx_rd != tx_wr) begin
				full_before = tx_is_full();
				r.tx_byte = tx_ring[tx_rd];
				tx_rd = tx_rd + 1'b1;
				r.done = 1'b1;
				// draining a full ring re-arms THRE
				if (full_before) begin
					thre = 1'b1;
					rise = !was_up && irq_up();
				end
			end
		end
		endcase
		if (rise)
			irq_cnt++;
		r.irq_level = irq_up();
		r.irq_edge = rise;
		r.dropped = drop_cnt;
		r.written = sent_cnt;
		r.events = irq_cnt;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, what, exp_val, act_val);
			errors++;
		end
	endtask

	// Check each reply beat against the oldest prediction, then predict for a new request beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier = '0;
			lcr = '0;
			mcr = '0;
			scr = '0;
			dll = DLL_RESET;
			dlm = '0;
			thre = 1'b0;
			tx_rd = '0;
			tx_wr = '0;
			rx_rd = '0;
			rx_wr = '0;
			drop_cnt = '0;
			sent_cnt = '0;
			irq_cnt = '0;
			replies_due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.read_data = m_tdata[7:0];
				got.done = m_tdata[8];
				got.tx_byte = m_tdata[16:9];
				got.irq_level = m_tdata[17];
				got.irq_edge = m_tdata[18];
				got.dropped = m_tdata[50:19];
				got.written = m_tdata[82:51];
				got.events = m_tdata[114:83];
				if (replies_due.size() == 0) begin
					$display("%0t: reply beat with none expected, actual 0x%0h", $time, m_tdata);
					errors++;
				end else begin
					want = replies_due.pop_front();
					check_field("read_data", 32'(want.read_data), 32'(got.read_data));
					check_field("done_res", 32'(want.done), 32'(got.done));
					check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
					check_field("irq_level", 32'(want.irq_level), 32'(got.irq_level));
					check_field("irq_edge", 32'(want.irq_edge), 32'(got.irq_edge));
					check_field("tx_dropped_count", want.dropped, got.dropped);
					check_field("tx_written_count", want.written, got.written);
					check_field("irq_event_count", want.events, got.events);
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(reply_for(mode_t'(s_tdata[1:0]), s_tdata[4:2],
					s_tdata[12:5], s_tdata[20:13]));
			pending <= replies_due.size();
		end
	end

endmodule

[tb/tb_uart_16550_register_model_core.sv]
// Testbench top for the UART register model: drives request beats with random gaps,
// throttles the reply side, and gives the verdict from uart_reply_checker.
// Depends on u16550_pkg, uart_16550_register_model_core and uart_reply_checker.
module tb_uart_16550_register_model_core import u16550_pkg::*;;

	localparam int ITEM_TARGET    = 2025;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_BITS-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;

	int errors, pending;
	int items_sent = 0;
	int quiet_cycles = 0;
	int burst_len, ready_gap;
	bit calm = 1'b0;

	always #10 clk = ~clk;

	uart_16550_register_model_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	uart_reply_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	// Wait out a random gap, then hold one request beat until it is taken
	task automatic send_item(input mode_t op, input logic [2:0] off,
			input logic [7:0] wdata, input logic [7:0] rbyte);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, rbyte, wdata, off, op};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Stall the reply side for a random number of cycles per beat
	initial begin
		wait (arst_n);
		forever begin
			ready_gap = calm ? 0 : $urandom_range(0, 18);
			if (ready_gap > 0) begin
				m_tready <= 1'b0;
				repeat (ready_gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, empty rings and fixed registers
		send_item(MODE_BUS_READ, OFF_LSR, 8'h00, 8'h00);
		send_item(MODE_BUS_READ, OFF_MSR, 8'h00, 8'h00);
		send_item(MODE_BUS_READ, OFF_IIR, 8'h00, 8'h00);
		send_item(MODE_BUS_READ, OFF_DATA, 8'h00, 8'h00);
		send_item(MODE_TX_POP, OFF_DATA, 8'h00, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_SCR, 8'hFF, 8'h00);
		send_item(MODE_BUS_READ, OFF_SCR, 8'h00, 8'h00);
		// Divisor latch aliasing under DLAB
		send_item(MODE_BUS_WRITE, OFF_LCR, 8'hFF, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_DATA, 8'hFF, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_IER, 8'h00, 8'h00);
		send_item(MODE_BUS_READ, OFF_DATA, 8'h00, 8'h00);
		send_item(MODE_BUS_READ, OFF_IER, 8'h00, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_LCR, 8'h00, 8'h00);
		// Plain registers, and writes that are ignored
		send_item(MODE_BUS_WRITE, OFF_MCR, 8'h1F, 8'h00);
		send_item(MODE_BUS_READ, OFF_MCR, 8'h00, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_IIR, 8'hC7, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_LSR, 8'hFF, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_MSR, 8'hFF, 8'h00);
		// Interrupt paths: THRE armed by IER, cleared by IIR, receive data on top
		send_item(MODE_BUS_WRITE, OFF_IER, 8'h03, 8'h00);
		send_item(MODE_BUS_READ, OFF_IIR, 8'h00, 8'h00);
		send_item(MODE_RX_PUSH, OFF_DATA, 8'h00, 8'hFF);
		send_item(MODE_BUS_READ, OFF_IIR, 8'h00, 8'h00);
		send_item(MODE_BUS_READ, OFF_DATA, 8'h00, 8'h00);
		send_item(MODE_BUS_WRITE, OFF_DATA, 8'h00, 8'h00);
		send_item(MODE_TX_POP, OFF_DATA, 8'h00, 8'h00);

		// Random bursts that fill and drain both rings, with register traffic and noise
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
			0: begin
				send_item(MODE_BUS_WRITE, OFF_LCR, 8'($urandom_range(0, 127)), rnd8());
				burst_len = $urandom_range(150, 360);
				repeat (burst_len)
					if ($urandom_range(0, 15) == 0)
						send_item(MODE_TX_POP, 3'($urandom_range(0, 7)), rnd8(), rnd8());
					else
						send_item(MODE_BUS_WRITE, OFF_DATA, rnd8(), rnd8());
			end
			1: begin
				burst_len = $urandom_range(50, 300);
				repeat (burst_len)
					if ($urandom_range(0, 5) == 0)
						send_item(MODE_BUS_READ, $urandom_range(0, 1) ? OFF_IIR : OFF_LSR,
							rnd8(), rnd8());
					else
						send_item(MODE_TX_POP, 3'($urandom_range(0, 7)), rnd8(), rnd8());
			end
			2: begin
				burst_len = $urandom_range(20, 90);
				repeat (burst_len)
					if ($urandom_range(0, 7) == 0)
						send_item(MODE_BUS_READ, OFF_LSR, rnd8(), rnd8());
					else
						send_item(MODE_RX_PUSH, 3'($urandom_range(0, 7)), rnd8(), rnd8());
			end
			3: begin
				send_item(MODE_BUS_WRITE, OFF_LCR, 8'($urandom_range(0, 127)), rnd8());
				burst_len = $urandom_range(20, 90);
				repeat (burst_len)
					if ($urandom_range(0, 4) == 0)
						send_item(MODE_BUS_READ, $urandom_range(0, 1) ? OFF_IIR : OFF_LSR,
							rnd8(), rnd8());
					else
						send_item(MODE_BUS_READ, OFF_DATA, rnd8(), rnd8());
			end
			4: begin
				burst_len = $urandom_range(10, 40);
				repeat (burst_len)
					send_item(mode_t'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
						rnd8(), rnd8());
			end
			default: begin
				burst_len = $urandom_range(10, 50);
				repeat (burst_len)
					send_item(mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						rnd8(), rnd8());
			end
			endcase
		end
		s_tvalid <= 1'b0;

		// Drain outstanding replies, then settle
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
design/u16550_pkg.sv
design/u16550_ring.sv
design/u16550_regs.sv
design/uart_16550_register_model_core.sv
tb/uart_reply_checker.sv
tb/tb_uart_16550_register_model_core.sv
